/* hdl/css_pkg.sv */
// shared types, codes and helpers for the caseless substring search core
// no dependencies; imported by every module of the block
package css_pkg;

    // tuser selector of a slave-side request
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TEXT = 1'b1;

    localparam int IDX_W    = 5;
    localparam int BYTE_W   = 8;
    localparam int LEN_CFG_W = 6;
    localparam int OFS_W    = 16;
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 24;

    // control broadcast to every cell of the row
    typedef struct packed {
        logic step;   // text byte compared this cycle
        logic flush;  // vector cleared this cycle
    } t_cell_ctl;

    // only upper-case ascii letters fold
    function automatic logic [BYTE_W-1:0] fold_byte(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] r;
        r = b;
        if (b >= 8'h41 && b <= 8'h5A) begin
            r = b + 8'h20;
        end
        return r;
    endfunction

endpackage

/* hdl/css_cell.sv */
// one pattern position: folded pattern byte and its partial-match bit
// depends on css_pkg
module css_cell
    import css_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr,
    input  logic [BYTE_W-1:0] i_wdata,
    input  logic [BYTE_W-1:0] i_text,
    input  t_cell_ctl         i_ctl,
    input  logic              i_en,
    input  logic              i_prev,
    output logic              o_pm,
    output logic              o_hit
);

    logic [BYTE_W-1:0] r_pat;
    logic              r_pm;
    logic              n_pm;

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_pat <= i_wdata;
        end
    end

    assign o_hit = i_en && i_prev && (r_pat == i_text);

    always_comb begin
        n_pm = r_pm;
        if (i_ctl.flush) begin
            n_pm = 1'b0;
        end else if (i_ctl.step) begin
            n_pm = o_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pm <= 1'b0;
        end else begin
            r_pm <= n_pm;
        end
    end

    assign o_pm = r_pm;

endmodule

/* hdl/caseless_substring_search_core.sv */
// channel  | dir | signals                              | payload
// slave    | in  | i_s_tvalid o_s_tready tdata tuser tlast | index, byte / cmd / last
// master   | out | o_m_tvalid i_m_tready tdata          | found, offset, too_long
// config   | in  | i_cfg_we i_cfg_wdata                 | pattern_length
// one request per cycle while the slave side is not stalled; a row of PATTERN_MAX cells compares each text byte
// the result shows in the cycle after the last text byte, from the output register
// the slave side stalls only while that output register is full and not taken
// reset clears the match vector, count, flags and length; pattern bytes are kept
// depends on css_pkg and css_cell
module caseless_substring_search_core
    import css_pkg::*;
#(
    parameter int PATTERN_MAX = 32,
    parameter int TEXT_MAX    = 65536
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [S_DATA_W-1:0]  i_s_tdata,   // [4:0] pattern_index, [12:5] data_byte
    input  logic                 i_s_tuser,   // [0] cmd
    input  logic                 i_s_tlast,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [M_DATA_W-1:0]  o_m_tdata,   // [0] found, [16:1] match_offset, [17] too_long
    input  logic                 i_cfg_we,
    input  logic [LEN_CFG_W-1:0] i_cfg_wdata
);

    localparam int CNT_W = $clog2(TEXT_MAX + 1);
    localparam int LEN_W = $clog2(PATTERN_MAX + 1);
    localparam int OW    = (CNT_W > OFS_W) ? CNT_W : OFS_W;

    logic [LEN_CFG_W-1:0] r_len;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic                 r_seen, n_seen;
    logic [OFS_W-1:0]     r_ofs, n_ofs;
    logic                 r_ovf, n_ovf;
    logic                 r_out_valid;
    logic [M_DATA_W-1:0]  r_out_data, n_out_data;

    logic [LEN_W-1:0]       len_act;
    logic [PATTERN_MAX-1:0] pm, hit;
    logic                   acc, is_text, over, last_hit;
    logic [IDX_W-1:0]       idx;
    logic [BYTE_W-1:0]      byte_f;
    logic [OW-1:0]          ofs_full;
    t_cell_ctl              ctl;

    assign o_s_tready = !r_out_valid || i_m_tready;
    assign acc        = i_s_tvalid && o_s_tready;
    assign is_text    = acc && (i_s_tuser == CMD_TEXT);
    assign idx        = i_s_tdata[IDX_W-1:0];
    assign byte_f     = fold_byte(i_s_tdata[IDX_W +: BYTE_W]);
    assign over       = (32'(r_cnt) >= TEXT_MAX);

    assign len_act = (32'(r_len) > PATTERN_MAX) ? LEN_W'(PATTERN_MAX) : LEN_W'(r_len);

    assign ctl.step  = is_text && !over;
    assign ctl.flush = is_text && (over || i_s_tlast);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
        end else if (i_cfg_we) begin
            r_len <= i_cfg_wdata;
        end
    end

    for (genvar g = 0; g < PATTERN_MAX; g++) begin : g_cell
        css_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_wr    (acc && (i_s_tuser == CMD_LOAD) && (32'(idx) == g)),
            .i_wdata (byte_f),
            .i_text  (byte_f),
            .i_ctl   (ctl),
            .i_en    (32'(len_act) > g),
            .i_prev  ((g == 0) ? 1'b1 : pm[(g == 0) ? 0 : g - 1]),
            .o_pm    (pm[g]),
            .o_hit   (hit[g])
        );
    end

    // pick the bit of the last pattern position in use
    always_comb begin
        last_hit = 1'b0;
        for (int i = 0; i < PATTERN_MAX; i++) begin
            if (32'(len_act) == i + 1) begin
                last_hit = hit[i];
            end
        end
    end

    assign ofs_full = OW'(r_cnt) + OW'(1) - OW'(len_act);

    always_comb begin
        n_cnt  = r_cnt;
        n_seen = r_seen;
        n_ofs  = r_ofs;
        n_ovf  = r_ovf;
        if (is_text) begin
            if (over) begin
                n_ovf = 1'b1;
            end else begin
                n_cnt = r_cnt + CNT_W'(1);
                if (len_act != '0 && last_hit && !r_seen) begin
                    n_seen = 1'b1;
                    n_ofs  = ofs_full[OFS_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_seen <= 1'b0;
            r_ofs  <= '0;
            r_ovf  <= 1'b0;
        end else if (is_text && i_s_tlast) begin
            r_cnt  <= '0;
            r_seen <= 1'b0;
            r_ofs  <= '0;
            r_ovf  <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_seen <= n_seen;
            r_ofs  <= n_ofs;
            r_ovf  <= n_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (is_text && i_s_tlast) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_comb begin
        n_out_data = '0;
        if (len_act == '0) begin
            n_out_data[0] = 1'b1;
        end else begin
            n_out_data[0]       = n_seen;
            n_out_data[OFS_W:1] = n_seen ? n_ofs : '0;
        end
        n_out_data[OFS_W+1] = n_ovf;
    end

    always_ff @(posedge i_clk) begin
        if (is_text && i_s_tlast) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

/* hdl/css_checker.sv */
// port-level checks for the caseless substring search core, and their bind
// depends on css_pkg and caseless_substring_search_core
module css_checker
    import css_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_s_tvalid,
    input logic                o_s_tready,
    input logic                i_s_tuser,
    input logic                i_s_tlast,
    input logic                o_m_tvalid,
    input logic                i_m_tready,
    input logic [M_DATA_W-1:0] o_m_tdata
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    a_ofs_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tdata[0] |-> o_m_tdata[OFS_W:1] == '0)
        else $error("offset not zero on a miss");

    a_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |->
            $past(i_s_tvalid && o_s_tready && i_s_tuser == CMD_TEXT && i_s_tlast))
        else $error("result without a last text byte");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("stalled with empty output register");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

endmodule

bind caseless_substring_search_core css_checker u_css_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tuser  (i_s_tuser),
    .i_s_tlast  (i_s_tlast),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
